@@ sv/itr_pkg.sv @@
// Shared types and constants of the radix text converter.
`default_nettype none
package itr_pkg;

    localparam int RADIX_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_CHARS = 16;
    localparam int ALPHA_IDX_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]    RADIX_RESET         = 5'd10;
    localparam logic [RADIX_W-1:0]    MIN_RADIX           = 5'd2;
    localparam logic [CFG_DATA_W-1:0] ALPHABET_LOW_RESET  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] ALPHABET_HIGH_RESET = 64'h4645444342413938;

    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

    typedef logic [ALPHA_CHARS-1:0][CHAR_W-1:0] alphabet_t;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        alphabet_t          alphabet;
    } cfg_t;

endpackage
`default_nettype wire

@@ sv/integer_to_radix_text.sv @@
// Top level of the radix text converter: configuration registers and the three stages.
//
// Each accepted value is printed in the configured radix as a run of characters on the
// m_ channel: an optional '-', the digits most significant first, then a newline with
// m_last set. A bad alphabet (radix below 2 or above MAX_RADIX, '+' or '-' among the
// characters in use, or a repeated character) gives one result with m_bad_alphabet and
// m_last set and a zero character. The back end divides the value by the radix once
// per digit, one 8-bit division slice per cycle, stacks the digits and then sends the
// characters as the output takes them. The front end classifies items into a two-entry
// queue, so the next values are taken while a run is still being printed. Write
// configuration only while no item is in flight.
`default_nettype none
module integer_to_radix_text #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [itr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [itr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [VALUE_BITS-1:0]     s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [itr_pkg::CHAR_W-1:0]            m_text_char,
    output logic                                  m_last,
    output logic                                  m_bad_alphabet
);
    import itr_pkg::*;

    localparam int ITEM_W = VALUE_BITS + 2;

    logic [RADIX_W-1:0]    radix_reg;
    logic [CFG_DATA_W-1:0] alpha_low_reg, alpha_high_reg;
    cfg_t                  cfg;

    logic                  q_full, q_push, q_pop, q_valid;
    logic                  f_bad, f_neg;
    logic [VALUE_BITS-1:0] f_mag;
    logic [ITEM_W-1:0]     q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= RADIX_RESET;
            alpha_low_reg  <= ALPHABET_LOW_RESET;
            alpha_high_reg <= ALPHABET_HIGH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RADIX:         radix_reg      <= cfg_wdata[RADIX_W-1:0];
                REG_ALPHABET_LOW:  alpha_low_reg  <= cfg_wdata;
                REG_ALPHABET_HIGH: alpha_high_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign cfg.radix    = radix_reg;
    assign cfg.alphabet = alphabet_t'({alpha_high_reg, alpha_low_reg});

    itr_front #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .q_full   (q_full),
        .q_push   (q_push),
        .item_bad (f_bad),
        .item_neg (f_neg),
        .item_mag (f_mag)
    );

    itr_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_bad, f_neg, f_mag}),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .pop_data  (q_data)
    );

    itr_back #(
        .MAX_RADIX  (MAX_RADIX),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .item_bad       (q_data[ITEM_W-1]),
        .item_neg       (q_data[ITEM_W-2]),
        .item_mag       (q_data[VALUE_BITS-1:0]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_text_char    (m_text_char),
        .m_last         (m_last),
        .m_bad_alphabet (m_bad_alphabet)
    );

endmodule
`default_nettype wire

@@ sv/itr_front.sv @@
// Front end: checks the alphabet, splits the value into sign and magnitude.
`default_nettype none
module itr_front #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire itr_pkg::cfg_t           cfg,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [VALUE_BITS-1:0] s_value,
    input  wire logic                    q_full,
    output logic                         q_push,
    output logic                         item_bad,
    output logic                         item_neg,
    output logic [VALUE_BITS-1:0]        item_mag
);
    import itr_pkg::*;

    logic                  alpha_ok;
    logic [VALUE_BITS-1:0] value_u;

    always_comb begin
        alpha_ok = 1'b1;
        if (cfg.radix < MIN_RADIX || cfg.radix > RADIX_W'(MAX_RADIX)) begin
            alpha_ok = 1'b0;
        end
        for (int a = 0; a < ALPHA_CHARS; a++) begin
            if (RADIX_W'(a) < cfg.radix) begin
                if (cfg.alphabet[a] == CHAR_PLUS || cfg.alphabet[a] == CHAR_MINUS) begin
                    alpha_ok = 1'b0;
                end
                for (int b = a + 1; b < ALPHA_CHARS; b++) begin
                    if (RADIX_W'(b) < cfg.radix && cfg.alphabet[b] == cfg.alphabet[a]) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign value_u  = $unsigned(s_value);
    assign item_neg = value_u[VALUE_BITS-1];
    // most negative value wraps to itself, which is the right unsigned magnitude
    assign item_mag = item_neg ? (~value_u + VALUE_BITS'(1)) : value_u;
    assign item_bad = ~alpha_ok;
    assign s_ready  = ~q_full;
    assign q_push   = s_valid & ~q_full;

endmodule
`default_nettype wire

@@ sv/itr_queue.sv @@
// Two-entry queue of classified items between front and back end.
`default_nettype none
module itr_queue #(
    parameter int WIDTH = 34
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  q_valid,
    output logic [WIDTH-1:0]      pop_data
);
    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_valid |-> !pop) else $error("queue pop while empty");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> q_valid) else $error("queue lost a pushed item");

endmodule
`default_nettype wire

@@ sv/itr_back.sv @@
// Back end: repeated division by the radix, digit stack and character output.
`default_nettype none
module itr_back #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire itr_pkg::cfg_t         cfg,
    input  wire logic                  q_valid,
    output logic                       q_pop,
    input  wire logic                  item_bad,
    input  wire logic                  item_neg,
    input  wire logic [VALUE_BITS-1:0] item_mag,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [itr_pkg::CHAR_W-1:0] m_text_char,
    output logic                       m_last,
    output logic                       m_bad_alphabet
);
    import itr_pkg::*;

    localparam int STEPS      = 8;
    localparam int CHUNKS     = (VALUE_BITS + STEPS - 1) / STEPS;
    localparam int WORK_W     = CHUNKS * STEPS;
    localparam int CNT_W      = $clog2(CHUNKS + 1);
    localparam int DIGIT_BITS = $clog2(MAX_RADIX);
    localparam int ND_W       = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_DIGIT = 3'd3;
    localparam logic [2:0] S_NL    = 3'd4;
    localparam logic [2:0] S_BAD   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [WORK_W-1:0]     work_reg, work_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ND_W-1:0]       nd_reg, nd_next;
    logic                  neg_reg, neg_next;
    logic [DIGIT_BITS-1:0] stack_reg [VALUE_BITS];
    logic                  push_digit, pop_digit;

    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  bad_reg, bad_next;

    logic                  out_free;
    logic [WORK_W-1:0]     div_work;
    logic [DIGIT_BITS-1:0] div_rem;

    // eight restoring-division steps a cycle, quotient bits shift in at the bottom
    always_comb begin
        logic [RADIX_W-1:0] t;
        logic [RADIX_W-1:0] diff;
        div_work = work_reg;
        div_rem  = rem_reg;
        for (int i = 0; i < STEPS; i++) begin
            t        = RADIX_W'({div_rem, div_work[WORK_W-1]});
            div_work = {div_work[WORK_W-2:0], 1'b0};
            diff     = t - cfg.radix;
            if (t >= cfg.radix) begin
                div_rem     = diff[DIGIT_BITS-1:0];
                div_work[0] = 1'b1;
            end else begin
                div_rem = t[DIGIT_BITS-1:0];
            end
        end
    end

    assign out_free = ~m_valid_reg | m_ready;

    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        nd_next      = nd_reg;
        neg_next     = neg_reg;
        push_digit   = 1'b0;
        pop_digit    = 1'b0;
        q_pop        = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        bad_next     = bad_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    work_next  = WORK_W'(item_mag);
                    rem_next   = '0;
                    cnt_next   = '0;
                    nd_next    = '0;
                    neg_next   = item_neg;
                    state_next = item_bad ? S_BAD : S_DIV;
                end
            end
            S_DIV: begin
                work_next = div_work;
                if (cnt_reg == CNT_W'(CHUNKS - 1)) begin
                    push_digit = 1'b1;
                    nd_next    = nd_reg + ND_W'(1);
                    rem_next   = '0;
                    cnt_next   = '0;
                    if (div_work == '0) begin
                        state_next = neg_reg ? S_SIGN : S_DIGIT;
                    end
                end else begin
                    rem_next = div_rem;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = CHAR_MINUS;
                    last_next    = 1'b0;
                    bad_next     = 1'b0;
                    state_next   = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = cfg.alphabet[ALPHA_IDX_W'(stack_reg[0])];
                    last_next    = 1'b0;
                    bad_next     = 1'b0;
                    pop_digit    = 1'b1;
                    nd_next      = nd_reg - ND_W'(1);
                    if (nd_reg == ND_W'(1)) begin
                        state_next = S_NL;
                    end
                end
            end
            S_NL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = CHAR_NEWLINE;
                    last_next    = 1'b1;
                    bad_next     = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_BAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    char_next    = CHAR_NONE;
                    last_next    = 1'b1;
                    bad_next     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // digit stack: push at the top, pop from the top
    always_ff @(posedge aclk) begin
        if (push_digit) begin
            stack_reg[0] <= div_rem;
            for (int i = 1; i < VALUE_BITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop_digit) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
            stack_reg[VALUE_BITS-1] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            nd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            nd_reg      <= nd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_text_char    = char_reg;
    assign m_last         = last_reg;
    assign m_bad_alphabet = bad_reg;

    a_digit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIGIT |-> nd_reg != '0) else $error("digit output with empty stack");
    a_stack_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_digit |-> nd_reg < ND_W'(VALUE_BITS)) else $error("digit stack overflow");
    a_bad_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_alphabet) |-> (m_last && m_text_char == CHAR_NONE))
        else $error("error result carries a character");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg != S_IDLE) else $error("item taken but not started");

endmodule
`default_nettype wire

@@ verif/integer_to_radix_text_tb.sv @@
// Self-checking testbench for integer_to_radix_text: random values, configs and flow control.
module integer_to_radix_text_tb;
    import itr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 1500;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
        logic              bad_alphabet;
    } text_out_t;

    class text_scoreboard;
        logic [RADIX_W-1:0] radix;
        alphabet_t          alphabet;
        text_out_t          expected_chars[$];
        int                 errors;

        function new();
            radix = RADIX_RESET;
            alphabet = {ALPHABET_HIGH_RESET, ALPHABET_LOW_RESET};
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RADIX: radix = data[RADIX_W-1:0];
                REG_ALPHABET_LOW: alphabet[7:0] = data;
                REG_ALPHABET_HIGH: alphabet[15:8] = data;
                default: ;
            endcase
        endfunction

        function bit alphabet_valid();
            if (radix < MIN_RADIX || radix > ALPHA_CHARS)
                return 1'b0;
            for (int a = 0; a < radix; a++) begin
                if (alphabet[a] == CHAR_PLUS || alphabet[a] == CHAR_MINUS)
                    return 1'b0;
                for (int b = a + 1; b < radix; b++)
                    if (alphabet[b] == alphabet[a])
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_value(logic signed [31:0] value);
            logic [31:0]            mag;
            logic [31:0]            base;
            logic [ALPHA_IDX_W-1:0] digits[$];
            if (!alphabet_valid()) begin
                expected_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
                return;
            end
            base = 32'(radix);
            mag = value;
            if (value[31])
                mag = ~mag + 32'd1;
            // zero still yields one digit
            do begin
                digits.push_front(ALPHA_IDX_W'(mag % base));
                mag = mag / base;
            end while (mag != 0);
            if (value[31])
                expected_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
            foreach (digits[i])
                expected_chars.push_back('{alphabet[digits[i]], 1'b0, 1'b0});
            expected_chars.push_back('{CHAR_NEWLINE, 1'b1, 1'b0});
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last, logic bad);
            text_out_t exp_out;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected char %h last %b bad %b", ch, last, bad));
                return;
            end
            exp_out = expected_chars.pop_front();
            if (ch !== exp_out.text_char)
                report($sformatf("text_char %h, expected %h", ch, exp_out.text_char));
            if (last !== exp_out.last)
                report($sformatf("last %b, expected %b", last, exp_out.last));
            if (bad !== exp_out.bad_alphabet)
                report($sformatf("bad_alphabet %b, expected %b", bad, exp_out.bad_alphabet));
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic signed [31:0]      s_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [CHAR_W-1:0]       m_text_char;
    logic                    m_last;
    logic                    m_bad_alphabet;

    text_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int cycle_count = 0;

    integer_to_radix_text u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_text_char    (m_text_char),
        .m_last         (m_last),
        .m_bad_alphabet (m_bad_alphabet)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_char(m_text_char, m_last, m_bad_alphabet);
    end

    // receiver: random stalls, or a long hold-off so the block backs up
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    task automatic send_value(input logic signed [31:0] value);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_value(value);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [RADIX_W-1:0] rdx, input alphabet_t chars);
        write_reg(REG_RADIX, CFG_DATA_W'(rdx));
        write_reg(REG_ALPHABET_LOW, chars[7:0]);
        write_reg(REG_ALPHABET_HIGH, chars[15:8]);
        cfg_we <= 1'b0;
    endtask

    // distinct characters without signs; optionally break the alphabet or radix
    task automatic pick_config(input bit broken, input logic [RADIX_W-1:0] base,
                               output logic [RADIX_W-1:0] rdx, output alphabet_t chars);
        logic [CHAR_W-1:0] c;
        bit                clash;
        int                k;
        for (int i = 0; i < ALPHA_CHARS; i++) begin
            do begin
                c = CHAR_W'($urandom_range(255));
                clash = (c == CHAR_PLUS || c == CHAR_MINUS);
                for (int j = 0; j < i; j++)
                    if (chars[j] == c)
                        clash = 1'b1;
            end while (clash);
            chars[i] = c;
        end
        rdx = base;
        if (broken) begin
            case ($urandom_range(3))
                0: rdx = $urandom_range(1) ? RADIX_W'($urandom_range(1))
                                           : RADIX_W'($urandom_range(17, 31));
                1: chars[$urandom_range(rdx - 1)] = CHAR_PLUS;
                2: chars[$urandom_range(rdx - 1)] = CHAR_MINUS;
                default: begin
                    k = $urandom_range(1, rdx - 1);
                    chars[k] = chars[$urandom_range(k - 1)];
                end
            endcase
        end
    endtask

    function automatic logic signed [31:0] random_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: return r;
            1: return 32'($urandom_range(40)) - 32'sd20;
            2: begin
                case ($urandom_range(4))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return r >>> $urandom_range(31);
        endcase
    endfunction

    initial begin
        logic [RADIX_W-1:0] rdx;
        alphabet_t          alpha;
        bit                 broken;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_value = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset configuration: decimal
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        send_value(-32'sd10);

        // binary: the most negative value gives the longest run
        wait_idle();
        alpha = {ALPHABET_HIGH_RESET, ALPHABET_LOW_RESET};
        set_config(MIN_RADIX, alpha);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sd0);

        // full alphabet with a zero byte as a digit
        wait_idle();
        alpha = {64'hFFEE_DDCC_BBAA_9988, 64'h8079_6A5B_4C3D_2E00};
        set_config(5'd16, alpha);
        send_value(32'sd0);
        send_value(-32'sd1);
        send_value(32'shFEDC_BA98);

        // bad radix, signs and repeats in use; signs and repeats past the radix are fine
        for (int i = 0; i < 8; i++) begin
            wait_idle();
            alpha = {ALPHABET_HIGH_RESET, ALPHABET_LOW_RESET};
            rdx = RADIX_RESET;
            case (i)
                0: rdx = 5'd0;
                1: rdx = 5'd1;
                2: rdx = 5'd17;
                3: rdx = 5'd31;
                4: alpha[3] = CHAR_PLUS;
                5: alpha[9] = CHAR_MINUS;
                6: alpha[9] = alpha[0];
                default: begin
                    alpha[12] = CHAR_PLUS;
                    alpha[15] = alpha[0];
                end
            endcase
            set_config(rdx, alpha);
            send_value(-32'sd1234567);
        end

        for (int phase = 0; phase < 12; phase++) begin
            wait_idle();
            broken = (phase == 9) || ($urandom_range(5) == 0);
            case (phase % 3)
                0: rdx = MIN_RADIX;
                1: rdx = 5'd16;
                default: rdx = RADIX_W'($urandom_range(3, 15));
            endcase
            pick_config(broken, rdx, rdx, alpha);
            set_config(rdx, alpha);
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 19; recv_stall = 19; end
            endcase
            if (phase == 6) begin
                send_idle = 0;
                recv_stall = 0;
                hold_left = HOLD_CYCLES;
            end
            repeat (24) send_value(random_value());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d chars never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/itr_pkg.sv
sv/itr_front.sv
sv/itr_queue.sv
sv/itr_back.sv
sv/integer_to_radix_text.sv
verif/integer_to_radix_text_tb.sv
